[sv/scma_pkg.sv]
// ----------------------------------------------------------------------------
// scma_pkg
// Sample and result types shared by the six-channel moving average and its
// stream interfaces.
// ----------------------------------------------------------------------------
package scma_pkg;

  localparam int CHANNELS = 6;
  localparam int SAMPLE_W = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t accel_x;
    sample_t accel_y;
    sample_t accel_z;
    sample_t rate_roll;
    sample_t rate_pitch;
    sample_t rate_yaw;
  } imu_sample_t;

  typedef struct packed {
    sample_t avg_accel_x;
    sample_t avg_accel_y;
    sample_t avg_accel_z;
    sample_t avg_rate_roll;
    sample_t avg_rate_pitch;
    sample_t avg_rate_yaw;
  } imu_avg_t;

endpackage

[sv/scma_stream_if.sv]
// ----------------------------------------------------------------------------
// scma_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface scma_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

[sv/six_channel_moving_average.sv]
// ----------------------------------------------------------------------------
// six_channel_moving_average
// Boxcar average over the last WINDOW samples of six IMU channels.
//
//   channel  direction  payload        transaction
//   in_chan  sink       imu_sample_t   one sample set (six channels)
//   out_chan source     imu_avg_t      one set of window averages
//
// One transaction per cycle sustained while out_chan does not stall; once its
// sample set is taken, each result passes the input, sum, product and output registers.
// History lives in a WINDOW-deep circular memory, one entry per sample set,
// read-before-write at the write pointer to fetch the sample that leaves.
// A running sum per channel is updated with new minus oldest; the division by
// WINDOW is a reciprocal multiply, one multiplier per channel.
// Reset is synchronous: sums and pointer clear, entries not yet written read
// as zero. Stalls on out_chan back up through the stages to in_chan.ready.
// ----------------------------------------------------------------------------
module six_channel_moving_average
  import scma_pkg::*;
#(
  parameter int WINDOW = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  scma_stream_if.sink   in_chan,
  scma_stream_if.source out_chan
);

  localparam int LOG_W  = $clog2(WINDOW);
  localparam int PTR_W  = (WINDOW > 1) ? LOG_W : 1;
  localparam int SUM_W  = SAMPLE_W + LOG_W;
  localparam int SHIFT  = SUM_W + LOG_W;
  localparam int MUL_W  = SUM_W + 1;
  localparam int PROD_W = SUM_W + MUL_W;
  localparam int QUO_W  = PROD_W - SHIFT;
  localparam logic [MUL_W-1:0] RECIP =
    MUL_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] entry_t;
  typedef logic signed [SUM_W-1:0]           sum_t;
  typedef logic [PROD_W-1:0]                 prod_t;

  entry_t mem [WINDOW];

  logic             in_fire;
  logic             adv2, adv3, adv4;
  logic             go1, go2, go3;
  logic             s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic [PTR_W-1:0] ptr_r;
  logic             wrapped_r;
  logic             old_ok_r;
  entry_t           in_vec;
  entry_t           new_r;
  entry_t           old_r;
  sum_t             sum_r  [CHANNELS];
  logic [SUM_W-1:0] mag    [CHANNELS];
  prod_t            prod_r [CHANNELS];
  logic             neg_r  [CHANNELS];
  logic [QUO_W-1:0] quo    [CHANNELS];
  entry_t           res_vec;
  entry_t           out_r;

  assign adv4    = !out_v_r || out_chan.ready;
  assign adv3    = !s3_v_r || adv4;
  assign adv2    = !s2_v_r || adv3;
  assign go1     = s1_v_r && adv2;
  assign go2     = s2_v_r && adv3;
  assign go3     = s3_v_r && adv4;
  assign in_chan.ready = !s1_v_r || adv2;
  assign in_fire = in_chan.valid && in_chan.ready;

  assign in_vec[0] = in_chan.data.accel_x;
  assign in_vec[1] = in_chan.data.accel_y;
  assign in_vec[2] = in_chan.data.accel_z;
  assign in_vec[3] = in_chan.data.rate_roll;
  assign in_vec[4] = in_chan.data.rate_pitch;
  assign in_vec[5] = in_chan.data.rate_yaw;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem[ptr_r] <= in_vec;
      old_r      <= mem[ptr_r];
      new_r      <= in_vec;
      old_ok_r   <= wrapped_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      wrapped_r <= 1'b0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        if (ptr_r == PTR_W'(WINDOW - 1)) begin
          ptr_r     <= '0;
          wrapped_r <= 1'b1;
        end else begin
          ptr_r <= ptr_r + 1'b1;
        end
      end
      s1_v_r  <= in_fire || (s1_v_r && !adv2);
      s2_v_r  <= go1 || (s2_v_r && !adv3);
      s3_v_r  <= go2 || (s3_v_r && !adv4);
      out_v_r <= go3 || (out_v_r && !out_chan.ready);
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    logic signed [SAMPLE_W-1:0] new_s;
    logic signed [SAMPLE_W-1:0] old_s;

    assign new_s = new_r[c];
    assign old_s = old_ok_r ? old_r[c] : '0;
    assign mag[c] = sum_r[c][SUM_W-1] ? SUM_W'(-sum_r[c]) : SUM_W'(sum_r[c]);
    assign quo[c] = prod_r[c][PROD_W-1:SHIFT];
    assign res_vec[c] = neg_r[c] ? SAMPLE_W'(-quo[c]) : SAMPLE_W'(quo[c]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sum_r[c] <= '0;
      end else if (go1) begin
        sum_r[c] <= sum_r[c] + SUM_W'(new_s) - SUM_W'(old_s);
      end
    end

    always_ff @(posedge clk) begin
      if (go2) begin
        prod_r[c] <= PROD_W'(mag[c]) * PROD_W'(RECIP);
        neg_r[c]  <= sum_r[c][SUM_W-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go3) begin
      out_r <= res_vec;
    end
  end

  assign out_chan.valid               = out_v_r;
  assign out_chan.data.avg_accel_x    = out_r[0];
  assign out_chan.data.avg_accel_y    = out_r[1];
  assign out_chan.data.avg_accel_z    = out_r[2];
  assign out_chan.data.avg_rate_roll  = out_r[3];
  assign out_chan.data.avg_rate_pitch = out_r[4];
  assign out_chan.data.avg_rate_yaw   = out_r[5];

`ifndef SYNTHESIS
  a_accept_enters_s1 : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_v_r)
    else $error("accepted transaction did not enter the first stage");

  a_wrap_sticky : assert property (@(posedge clk)
    rst_n && $past(rst_n) |-> !$fell(wrapped_r))
    else $error("history wrap flag dropped outside reset");

  a_ptr_moves : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (WINDOW > 1) |=> ptr_r != $past(ptr_r))
    else $error("write pointer held on an accepted transaction");

  a_out_from_s3 : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(s3_v_r))
    else $error("result raised without a transaction in the last stage");
`endif

endmodule

[sim/six_channel_moving_average_tb.sv]
// ----------------------------------------------------------------------------
// six_channel_moving_average_tb
// Self-checking bench for the six-channel boxcar average. A queue-fed driver
// offers sample sets and a clocked monitor predicts each window average on
// acceptance. Results are checked in order against that prediction. Phases
// vary source idling and sink stalling, and include one long sink hold-off.
// ----------------------------------------------------------------------------
module six_channel_moving_average_tb
  import scma_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int      WINDOW      = 8;
  localparam int      HOLD_CYCLES = 300;
  localparam int      CYCLE_LIMIT = 200000;
  localparam sample_t S_MAX       = 16'sh7fff;
  localparam sample_t S_MIN       = 16'sh8000;

  logic clk = 1'b0;
  logic rst_n;

  scma_stream_if #(.payload_t(imu_sample_t)) in_chan ();
  scma_stream_if #(.payload_t(imu_avg_t))    out_chan ();

  six_channel_moving_average #(.WINDOW(WINDOW)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  imu_sample_t sample_q[$];
  imu_avg_t    avg_q[$];
  sample_t     history [CHANNELS][WINDOW] = '{default: '0};
  imu_avg_t    want;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          hold_reqs     = 0;
  int          hold_taken    = 0;
  int          hold_left     = 0;
  int          errors        = 0;
  int          cycles        = 0;
  logic        in_taken      = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic sample_t shift_and_average(int ch, sample_t x);
    int acc;
    int k;
    acc = 0;
    for (k = WINDOW - 1; k > 0; k--) history[ch][k] = history[ch][k-1];
    history[ch][0] = x;
    for (k = 0; k < WINDOW; k++) acc += int'(history[ch][k]);
    return sample_t'(acc / WINDOW);
  endfunction

  function automatic imu_avg_t predict_window_average(imu_sample_t s);
    imu_avg_t r;
    r.avg_accel_x    = shift_and_average(0, s.accel_x);
    r.avg_accel_y    = shift_and_average(1, s.accel_y);
    r.avg_accel_z    = shift_and_average(2, s.accel_z);
    r.avg_rate_roll  = shift_and_average(3, s.rate_roll);
    r.avg_rate_pitch = shift_and_average(4, s.rate_pitch);
    r.avg_rate_yaw   = shift_and_average(5, s.rate_yaw);
    return r;
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? S_MAX : S_MIN;
      1: return sample_t'($signed($urandom_range(16)) - 8);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic check_field(string name, sample_t exp_v, sample_t act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // drive sample sets
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_taken) begin
      if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_chan.data  <= sample_q.pop_front();
        in_chan.valid <= 1'b1;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // stall results, with a long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_reqs != hold_taken) begin
      hold_taken     <= hold_reqs;
      hold_left      <= HOLD_CYCLES;
      out_chan.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left      <= hold_left - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // predict on input transaction, check on output transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_chan.valid && in_chan.ready;
      if (in_chan.valid && in_chan.ready) begin
        avg_q.push_back(predict_window_average(in_chan.data));
      end
      if (out_chan.valid && out_chan.ready) begin
        if (avg_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_chan.data);
        end else begin
          want = avg_q.pop_front();
          check_field("avg_accel_x", want.avg_accel_x, out_chan.data.avg_accel_x);
          check_field("avg_accel_y", want.avg_accel_y, out_chan.data.avg_accel_y);
          check_field("avg_accel_z", want.avg_accel_z, out_chan.data.avg_accel_z);
          check_field("avg_rate_roll", want.avg_rate_roll, out_chan.data.avg_rate_roll);
          check_field("avg_rate_pitch", want.avg_rate_pitch, out_chan.data.avg_rate_pitch);
          check_field("avg_rate_yaw", want.avg_rate_yaw, out_chan.data.avg_rate_yaw);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("six_channel_moving_average test failed");
      $finish;
    end
  end

  task automatic wait_until_drained();
    bit sender_idle;
    do begin
      @(posedge clk);
      sender_idle = (sample_q.size() == 0) && !in_chan.valid;
      @(negedge clk);
    end while (!(sender_idle && avg_q.size() == 0));
  endtask

  task automatic push_random(int n);
    int i;
    for (i = 0; i < n; i++) begin
      sample_q.push_back(imu_sample_t'{rand_sample(), rand_sample(), rand_sample(),
                                       rand_sample(), rand_sample(), rand_sample()});
    end
  endtask

  task automatic run_phase(int n, int idle, int stall);
    @(posedge clk);
    send_idle_pct = idle;
    stall_pct     = stall;
    push_random(n);
    wait_until_drained();
  endtask

  initial begin
    int i;
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.data   = '0;
    out_chan.ready = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    // start-up and truncation toward zero
    sample_q.push_back(imu_sample_t'{16'sd1, -16'sd1, 16'sd7, -16'sd7, 16'sd8, -16'sd8});
    sample_q.push_back(imu_sample_t'{-16'sd9, 16'sd9, 16'sd0, -16'sd1, 16'sd15, -16'sd15});
    for (i = 0; i < 8; i++) sample_q.push_back(imu_sample_t'{default: S_MAX});
    for (i = 0; i < 8; i++) sample_q.push_back(imu_sample_t'{default: S_MIN});
    for (i = 0; i < 4; i++) begin
      sample_q.push_back(i[0] ? imu_sample_t'{S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX}
                              : imu_sample_t'{S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN});
    end
    wait_until_drained();

    run_phase(140, 0, 0);
    run_phase(140, 77, 0);
    run_phase(140, 0, 77);
    run_phase(140, 25, 25);

    // hold the sink off while the source keeps offering
    @(posedge clk);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_reqs     = hold_reqs + 1;
    push_random(120);
    wait_until_drained();

    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("six_channel_moving_average test passed");
    end else begin
      $display("six_channel_moving_average test failed");
    end
    $finish;
  end

endmodule

[six_channel_moving_average.f]
sv/scma_pkg.sv
sv/scma_stream_if.sv
sv/six_channel_moving_average.sv
sim/six_channel_moving_average_tb.sv
